// ----- rtl/dvpx_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dvpx_pkg: shared types and constants for the vendor/product id extractor
// Holds character codes, the digit limit and the structs passed between the
// character classifier, the parser and the top level.
// ----------------------------------------------------------------------------
package dvpx_pkg;

	// Widths fixed by the character and id fields.
	localparam int CHAR_W = 16;
	localparam int ID_W   = 16;
	localparam int HEX_W  = 4;

	// Largest number of hex digits read for either id.
	localparam int MAX_HEX_DIGITS = 4;
	localparam int DCNT_W         = $clog2(MAX_HEX_DIGITS + 1);

	// Character codes that the parser looks for.
	localparam logic [CHAR_W-1:0] CH_NUL   = 16'h0000;
	localparam logic [CHAR_W-1:0] CH_UNDER = 16'h005F;
	localparam logic [CHAR_W-1:0] CH_AMP   = 16'h0026;
	localparam logic [CHAR_W-1:0] CH_0     = 16'h0030;
	localparam logic [CHAR_W-1:0] CH_9     = 16'h0039;
	localparam logic [CHAR_W-1:0] CH_UC_A  = 16'h0041;
	localparam logic [CHAR_W-1:0] CH_UC_F  = 16'h0046;
	localparam logic [CHAR_W-1:0] CH_LC_A  = 16'h0061;
	localparam logic [CHAR_W-1:0] CH_LC_F  = 16'h0066;
	localparam logic [CHAR_W-1:0] CH_UC_V  = 16'h0056;
	localparam logic [CHAR_W-1:0] CH_LC_V  = 16'h0076;
	localparam logic [CHAR_W-1:0] CH_UC_I  = 16'h0049;
	localparam logic [CHAR_W-1:0] CH_LC_I  = 16'h0069;
	localparam logic [CHAR_W-1:0] CH_UC_D  = 16'h0044;
	localparam logic [CHAR_W-1:0] CH_LC_D  = 16'h0064;
	localparam logic [CHAR_W-1:0] CH_UC_P  = 16'h0050;
	localparam logic [CHAR_W-1:0] CH_LC_P  = 16'h0070;

	// Offset added to the low nibble of a hex letter to give its value.
	localparam logic [HEX_W-1:0] HEX_LETTER_OFS = 4'd9;

	// Decoded view of one character.
	typedef struct packed {
		logic             is_nul;
		logic             is_hex;
		logic [HEX_W-1:0] hex;
		logic             is_v;
		logic             is_i;
		logic             is_d;
		logic             is_p;
		logic             is_under;
		logic             is_amp;
	} char_class_t;

	// One pair of ids as produced on a terminator.
	typedef struct packed {
		logic [ID_W-1:0] vendor_id;
		logic [ID_W-1:0] product_id;
	} id_pair_t;

endpackage : dvpx_pkg
`default_nettype wire

// ----- rtl/dvpx_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dvpx_if: valid/ready channels for the vendor/product id extractor
// The character channel carries one path character a beat; the id channel
// carries one vendor/product id pair a beat.
// ----------------------------------------------------------------------------
interface dvpx_char_if;
	import dvpx_pkg::*;

	logic              valid;
	logic              ready;
	logic [CHAR_W-1:0] code_unit;

	modport source (output valid, output code_unit, input ready);
	modport sink   (input valid, input code_unit, output ready);
endinterface : dvpx_char_if

interface dvpx_id_if;
	import dvpx_pkg::*;

	logic            valid;
	logic            ready;
	logic [ID_W-1:0] vendor_id;
	logic [ID_W-1:0] product_id;

	modport source (output valid, output vendor_id, output product_id, input ready);
	modport sink   (input valid, input vendor_id, input product_id, output ready);
endinterface : dvpx_id_if
`default_nettype wire

// ----- rtl/dvpx_char_class.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dvpx_char_class: character classifier
// Decodes one character into the flags and hex value that the parser uses.
// ----------------------------------------------------------------------------
module dvpx_char_class
	import dvpx_pkg::*;
(
	input  logic [CHAR_W-1:0] code_unit,
	output char_class_t       cls
);

	logic is_dec;
	logic is_uc_hex;
	logic is_lc_hex;

	// Range checks for the three groups of hex digits.
	assign is_dec    = (code_unit >= CH_0) && (code_unit <= CH_9);
	assign is_uc_hex = (code_unit >= CH_UC_A) && (code_unit <= CH_UC_F);
	assign is_lc_hex = (code_unit >= CH_LC_A) && (code_unit <= CH_LC_F);

	// Flags and digit value; letters take their low nibble plus nine.
	always_comb begin
		cls.is_nul   = (code_unit == CH_NUL);
		cls.is_hex   = is_dec || is_uc_hex || is_lc_hex;
		cls.hex      = is_dec ? code_unit[HEX_W-1:0] : code_unit[HEX_W-1:0] + HEX_LETTER_OFS;
		cls.is_v     = (code_unit == CH_UC_V) || (code_unit == CH_LC_V);
		cls.is_i     = (code_unit == CH_UC_I) || (code_unit == CH_LC_I);
		cls.is_d     = (code_unit == CH_UC_D) || (code_unit == CH_LC_D);
		cls.is_p     = (code_unit == CH_UC_P) || (code_unit == CH_LC_P);
		cls.is_under = (code_unit == CH_UNDER);
		cls.is_amp   = (code_unit == CH_AMP);
	end

endmodule : dvpx_char_class
`default_nettype wire

// ----- rtl/dvpx_parser.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dvpx_parser: path parser state machine
// Matches "vid_", reads the vendor digits, matches "&pid_" and reads the
// product digits, one classified character a step. Presents the id pair that
// a terminator at this step would give.
// ----------------------------------------------------------------------------
module dvpx_parser
	import dvpx_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        step,
	input  char_class_t cls,
	output id_pair_t    result
);

	typedef enum logic [3:0] {
		PH_SEARCH,
		PH_V,
		PH_VI,
		PH_VID,
		PH_VDIG,
		PH_AMP,
		PH_P,
		PH_PI,
		PH_PID,
		PH_UND,
		PH_PDIG,
		PH_OK,
		PH_FAIL
	} phase_t;

	phase_t            phase_q;
	logic [DCNT_W-1:0] dcnt_q;
	logic [ID_W-1:0]   vacc_q;
	logic [ID_W-1:0]   pacc_q;

	logic [DCNT_W-1:0] dcnt_inc;
	logic              at_limit;
	logic              ok;

	// Digit counter after this character and whether it reaches the limit.
	assign dcnt_inc = dcnt_q + DCNT_W'(1);
	assign at_limit = (dcnt_inc >= DCNT_W'(MAX_HEX_DIGITS));

	// Only a path that got as far as the product digits yields its ids.
	assign ok                = (phase_q == PH_PDIG) || (phase_q == PH_OK);
	assign result.vendor_id  = ok ? vacc_q : '0;
	assign result.product_id = ok ? pacc_q : '0;

	// State and accumulators; a terminator returns everything to reset values.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_SEARCH;
			dcnt_q  <= '0;
			vacc_q  <= '0;
			pacc_q  <= '0;
		end else if (step) begin
			if (cls.is_nul) begin
				phase_q <= PH_SEARCH;
				dcnt_q  <= '0;
				vacc_q  <= '0;
				pacc_q  <= '0;
			end else begin
				unique case (phase_q)
					PH_SEARCH, PH_V, PH_VI, PH_VID: begin
						if (phase_q == PH_V && cls.is_i) begin
							phase_q <= PH_VI;
						end else if (phase_q == PH_VI && cls.is_d) begin
							phase_q <= PH_VID;
						end else if (phase_q == PH_VID && cls.is_under) begin
							phase_q <= PH_VDIG;
							dcnt_q  <= '0;
							vacc_q  <= '0;
						end else begin
							// A broken match restarts; a 'v' opens a new one.
							phase_q <= cls.is_v ? PH_V : PH_SEARCH;
						end
					end
					PH_VDIG: begin
						if (cls.is_hex) begin
							vacc_q <= {vacc_q[ID_W-HEX_W-1:0], cls.hex};
							dcnt_q <= dcnt_inc;
							if (at_limit) begin
								phase_q <= PH_AMP;
							end
						end else if (dcnt_q == '0) begin
							phase_q <= PH_FAIL;
						end else begin
							phase_q <= cls.is_amp ? PH_P : PH_FAIL;
						end
					end
					PH_AMP: begin
						phase_q <= cls.is_amp ? PH_P : PH_FAIL;
					end
					PH_P: begin
						phase_q <= cls.is_p ? PH_PI : PH_FAIL;
					end
					PH_PI: begin
						phase_q <= cls.is_i ? PH_PID : PH_FAIL;
					end
					PH_PID: begin
						phase_q <= cls.is_d ? PH_UND : PH_FAIL;
					end
					PH_UND: begin
						if (cls.is_under) begin
							phase_q <= PH_PDIG;
							dcnt_q  <= '0;
							pacc_q  <= '0;
						end else begin
							phase_q <= PH_FAIL;
						end
					end
					PH_PDIG: begin
						if (cls.is_hex) begin
							pacc_q <= {pacc_q[ID_W-HEX_W-1:0], cls.hex};
							dcnt_q <= dcnt_inc;
							if (at_limit) begin
								phase_q <= PH_OK;
							end
						end else begin
							phase_q <= PH_OK;
						end
					end
					PH_OK, PH_FAIL: begin
						phase_q <= phase_q;
					end
					default: begin
						phase_q <= PH_FAIL;
					end
				endcase
			end
		end
	end

endmodule : dvpx_parser
`default_nettype wire

// ----- rtl/device_path_vid_pid_extractor_core.sv -----
`timescale 1ns / 1ps
`default_nettype none
// A result beat comes from the result register, loaded when its terminator steps the parser.
// Throughput: one character per cycle while no terminator is held, set by the parser
// step between the input register and the result register.
// A terminator holds in the input register while the previous result waits.
// Reset clears both valid flags and returns the parser to the search state.
// ----------------------------------------------------------------------------
// device_path_vid_pid_extractor_core: vendor/product id extractor
// Registers each path character, classifies it and steps the parser; on the
// terminator the id pair is captured in the result register.
// ----------------------------------------------------------------------------
module device_path_vid_pid_extractor_core
	import dvpx_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	dvpx_char_if.sink   chars,
	dvpx_id_if.source   ids
);

	logic              valid_s1;
	logic [CHAR_W-1:0] code_s1;
	logic              out_valid_q;
	id_pair_t          out_q;

	char_class_t       cls;
	id_pair_t          result;
	logic              out_free;
	logic              proc;

	// The parser steps unless a terminator would find the result slot taken.
	assign out_free    = !out_valid_q || ids.ready;
	assign proc        = valid_s1 && (!cls.is_nul || out_free);
	assign chars.ready = !valid_s1 || proc;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (chars.valid && chars.ready) begin
			valid_s1 <= 1'b1;
		end else if (proc) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (chars.valid && chars.ready) begin
			code_s1 <= chars.code_unit;
		end
	end

	dvpx_char_class u_class (
		.code_unit (code_s1),
		.cls       (cls)
	);

	dvpx_parser u_parser (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (proc),
		.cls    (cls),
		.result (result)
	);

	// Result register, loaded when a terminator is stepped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (proc && cls.is_nul) begin
			out_valid_q <= 1'b1;
		end else if (ids.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (proc && cls.is_nul) begin
			out_q <= result;
		end
	end

	assign ids.valid      = out_valid_q;
	assign ids.vendor_id  = out_q.vendor_id;
	assign ids.product_id = out_q.product_id;

	// A terminator is never stepped over a result that has not been taken.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		proc && cls.is_nul |-> out_free)
		else $error("terminator stepped while result register still full");

	// The input side stalls only on a held terminator.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!chars.ready |-> valid_s1 && cls.is_nul && out_valid_q && !ids.ready)
		else $error("input stalled without a waiting terminator");

	// A stepped terminator shows a result beat in the next cycle.
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		proc && cls.is_nul |=> ids.valid)
		else $error("terminator stepped but no result beat followed");

endmodule : device_path_vid_pid_extractor_core
`default_nettype wire
